// ----- rtl/core/positional_sequence_store_macros.svh -----
// Assertion macros used by the file that checks the sequence store.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef POSITIONAL_SEQUENCE_STORE_MACROS_SVH
`define POSITIONAL_SEQUENCE_STORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional_sequence_store: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional_sequence_store: next-cycle check failed");

`endif

// ----- rtl/core/pss_pkg.sv -----
package pss_pkg;

  // Fixed field widths of the request and response words.
  localparam int WORD_W    = 64;
  localparam int POS_W     = 8;
  localparam int REQ_W     = 3;
  localparam int LEN_OUT_W = 6;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [REQ_W-1:0]     req_code_t;
  typedef logic [LEN_OUT_W-1:0] len_out_t;

  // Request codes carried in req_type.
  localparam req_code_t REQ_INSERT  = 3'd0;
  localparam req_code_t REQ_REMOVE  = 3'd1;
  localparam req_code_t REQ_REVERSE = 3'd2;
  localparam req_code_t REQ_DUMP    = 3'd3;
  localparam req_code_t REQ_CLEAR   = 3'd4;

  // Memory port strobes from the sequencer.
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

// ----- rtl/core/positional_sequence_store.sv -----
// Ordered store of up to CAPACITY 64-bit words addressed by 1-based position.
// One request word is taken at a time; req_stall stays high until its last
// response word has been loaded into the output register. Insert shifts the
// words from the position upwards up, remove shifts the words above it down,
// reverse swaps pairs, dump reads out each element, and clear and failed
// requests touch no stored word. All of this goes through the single element
// memory, which does at most one read or one write per cycle, with every moved
// word read and then written. A stalled response holds the sequencer until the
// response register is free. The element memory needs no clearing after reset:
// positions beyond the length are never read.
`include "positional_sequence_store_macros.svh"

module positional_sequence_store #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         req_type,
  input  logic [7:0]         first_position,
  input  logic [7:0]         second_position,
  input  logic [63:0]        item_value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               ok,
  output logic [63:0]        element_value,
  output logic               last,
  output logic [5:0]         length_after
);

  localparam int AW = $clog2(CAPACITY);

  pss_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]     mem_raddr;
  logic [AW-1:0]     mem_waddr;
  pss_pkg::word_t    mem_wdata;
  pss_pkg::word_t    mem_rdata;

  // Sequencer with the response register.
  pss_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_type       (req_type),
    .first_position (first_position),
    .second_position(second_position),
    .item_value     (item_value),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .ok             (ok),
    .element_value  (element_value),
    .last           (last),
    .length_after   (length_after),
    .mem_ctl        (mem_ctl),
    .mem_raddr      (mem_raddr),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_rdata      (mem_rdata)
  );

  // Element memory.
  pss_mem #(
    .DEPTH(CAPACITY)
  ) u_mem (
    .clk  (clk),
    .ctl  (mem_ctl),
    .raddr(mem_raddr),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // Checks on the sequencer and its memory traffic.
  `PSS_ASSERT_SAME(a_idle_no_write, !req_stall, !mem_ctl.wr)
  `PSS_ASSERT_SAME(a_one_access, 1'b1, !(mem_ctl.rd && mem_ctl.wr))
  `PSS_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, req_stall)
  `PSS_ASSERT_SAME(a_read_in_range, mem_ctl.rd, int'(mem_raddr) < CAPACITY)

endmodule

// ----- rtl/core/pss_mem.sv -----
module pss_mem #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  pss_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     raddr,
  input  logic [AW-1:0]     waddr,
  input  pss_pkg::word_t    wdata,
  output pss_pkg::word_t    rdata
);

  pss_pkg::word_t mem [DEPTH];

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/pss_seq.sv -----
module pss_seq #(
  parameter int CAPACITY = 32,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  pss_pkg::req_code_t   req_type,
  input  pss_pkg::pos_t        first_position,
  input  pss_pkg::pos_t        second_position,
  input  pss_pkg::word_t       item_value,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic                 ok,
  output pss_pkg::word_t       element_value,
  output logic                 last,
  output pss_pkg::len_out_t    length_after,
  output pss_pkg::mem_ctl_t    mem_ctl,
  output logic [AW-1:0]        mem_raddr,
  output logic [AW-1:0]        mem_waddr,
  output pss_pkg::word_t       mem_wdata,
  input  pss_pkg::word_t       mem_rdata
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = LW + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_RD2  = 7'b0000100,
    S_WR   = 7'b0001000,
    S_WR2  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DOUT = 7'b1000000
  } state_t;

  state_t             state, state_next;
  logic [LW-1:0]      len, len_next;
  pss_pkg::req_code_t op, op_next;
  logic               pass, pass_next;
  logic [LW-1:0]      idx, idx_next;
  logic [LW-1:0]      hi, hi_next;
  logic [LW-1:0]      tgt, tgt_next;
  pss_pkg::word_t     val, val_next;
  pss_pkg::word_t     tmp, tmp_next;

  logic               rsp_load, rsp_ok_next, rsp_last_next;
  pss_pkg::word_t     rsp_value_next;
  logic [LW-1:0]      rsp_len_src;
  logic               rsp_free;

  logic [LW-1:0]      raddr_sel, waddr_sel;
  logic [LW-1:0]      idx_m1;
  logic [CW-1:0]      idx_c, hi_c, len_c;

  // Request decode works on widened positions so no compare can wrap.
  logic [8:0]         len9, p1, p2, cap9, ins_pos;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign len9    = 9'(len);
  assign p1      = 9'(first_position);
  assign p2      = 9'(second_position);
  assign cap9    = 9'(CAPACITY);
  assign ins_pos = (p1 > len9 + 9'd1) ? len9 + 9'd1 : p1;

  assign idx_m1 = idx - LW'(1);
  assign idx_c  = CW'(idx);
  assign hi_c   = CW'(hi);
  assign len_c  = CW'(len);

  assign mem_raddr = raddr_sel[AW-1:0];
  assign mem_waddr = waddr_sel[AW-1:0];

  // Sequencer: at most one memory access per cycle, read then write for every moved word.
  always_comb begin
    state_next     = state;
    len_next       = len;
    op_next        = op;
    pass_next      = pass;
    idx_next       = idx;
    hi_next        = hi;
    tgt_next       = tgt;
    val_next       = val;
    tmp_next       = tmp;
    mem_ctl        = '0;
    raddr_sel      = idx;
    waddr_sel      = idx;
    mem_wdata      = mem_rdata;
    rsp_load       = 1'b0;
    rsp_ok_next    = 1'b0;
    rsp_value_next = '0;
    rsp_last_next  = 1'b1;
    rsp_len_src    = len;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next  = req_type;
          val_next = item_value;
          case (req_type)
            pss_pkg::REQ_INSERT: begin
              if (len9 >= cap9 || p1 == 9'd0) begin
                pass_next  = 1'b0;
                state_next = S_FIN;
              end else begin
                pass_next  = 1'b1;
                idx_next   = len;
                tgt_next   = LW'(ins_pos - 9'd1);
                state_next = (len9 == ins_pos - 9'd1) ? S_FIN : S_RD;
              end
            end
            pss_pkg::REQ_REMOVE: begin
              if (len9 == 9'd0 || p1 == 9'd0 || p1 > len9) begin
                pass_next  = 1'b0;
                state_next = S_FIN;
              end else begin
                pass_next  = 1'b1;
                idx_next   = LW'(p1 - 9'd1);
                state_next = (p1 < len9) ? S_RD : S_FIN;
              end
            end
            pss_pkg::REQ_REVERSE: begin
              if (p1 == 9'd0 || p1 > len9 || p2 == 9'd0 || p2 > len9 || p1 > p2) begin
                pass_next  = 1'b0;
                state_next = S_FIN;
              end else begin
                pass_next  = 1'b1;
                idx_next   = LW'(p1 - 9'd1);
                hi_next    = LW'(p2 - 9'd1);
                state_next = (p1 < p2) ? S_RD : S_FIN;
              end
            end
            pss_pkg::REQ_DUMP: begin
              if (len9 == 9'd0) begin
                pass_next  = 1'b0;
                state_next = S_FIN;
              end else begin
                pass_next  = 1'b1;
                idx_next   = '0;
                state_next = S_RD;
              end
            end
            pss_pkg::REQ_CLEAR: begin
              pass_next  = 1'b1;
              state_next = S_FIN;
            end
            default: begin
              pass_next  = 1'b0;
              state_next = S_FIN;
            end
          endcase
        end
      end

      // Read the source word of the next move, the low word of a swap, or the next dumped element.
      S_RD: begin
        mem_ctl.rd = 1'b1;
        case (op)
          pss_pkg::REQ_INSERT: raddr_sel = idx_m1;
          pss_pkg::REQ_REMOVE: raddr_sel = idx + LW'(1);
          default:             raddr_sel = idx;
        endcase
        case (op)
          pss_pkg::REQ_REVERSE: state_next = S_RD2;
          pss_pkg::REQ_DUMP:    state_next = S_DOUT;
          default:              state_next = S_WR;
        endcase
      end

      // Second read of a swap; the low word is parked meanwhile.
      S_RD2: begin
        mem_ctl.rd = 1'b1;
        raddr_sel  = hi;
        tmp_next   = mem_rdata;
        state_next = S_WR;
      end

      // Write the word just read to its new place.
      S_WR: begin
        mem_ctl.wr = 1'b1;
        waddr_sel  = idx;
        mem_wdata  = mem_rdata;
        case (op)
          pss_pkg::REQ_INSERT: begin
            idx_next   = idx_m1;
            state_next = (idx_m1 == tgt) ? S_FIN : S_RD;
          end
          pss_pkg::REQ_REMOVE: begin
            idx_next   = idx + LW'(1);
            state_next = (idx_c + CW'(2) < len_c) ? S_RD : S_FIN;
          end
          default: begin
            state_next = S_WR2;
          end
        endcase
      end

      // Complete a swap and step both ends inwards.
      S_WR2: begin
        mem_ctl.wr = 1'b1;
        waddr_sel  = hi;
        mem_wdata  = tmp;
        idx_next   = idx + LW'(1);
        hi_next    = hi - LW'(1);
        state_next = (idx_c + CW'(2) < hi_c) ? S_RD : S_FIN;
      end

      // Write an inserted word, commit the length change and give the single response word.
      S_FIN: begin
        if (rsp_free) begin
          rsp_load    = 1'b1;
          rsp_ok_next = pass;
          if (pass) begin
            case (op)
              pss_pkg::REQ_INSERT: begin
                mem_ctl.wr = 1'b1;
                waddr_sel  = tgt;
                mem_wdata  = val;
                len_next   = len + LW'(1);
              end
              pss_pkg::REQ_REMOVE: len_next = len - LW'(1);
              pss_pkg::REQ_CLEAR:  len_next = '0;
              default:             len_next = len;
            endcase
          end
          rsp_len_src = len_next;
          state_next  = S_IDLE;
        end
      end

      // Hand out one stored element per response word.
      S_DOUT: begin
        if (rsp_free) begin
          rsp_load       = 1'b1;
          rsp_ok_next    = 1'b1;
          rsp_value_next = mem_rdata;
          rsp_last_next  = (idx_c + CW'(1) == len_c);
          if (idx_c + CW'(1) == len_c) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + LW'(1);
            state_next = S_RD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working registers and the response register.
  always_ff @(posedge clk) begin
    op   <= op_next;
    pass <= pass_next;
    idx  <= idx_next;
    hi   <= hi_next;
    tgt  <= tgt_next;
    val  <= val_next;
    tmp  <= tmp_next;
    if (rsp_load) begin
      ok            <= rsp_ok_next;
      element_value <= rsp_value_next;
      last          <= rsp_last_next;
      length_after  <= pss_pkg::len_out_t'(rsp_len_src);
    end
  end

endmodule

// ----- dv/positional_sequence_store_test.sv -----
module positional_sequence_store_test;

  localparam int DEPTH = 32;

  // Request codes that the block does not know; each must fail and change nothing.
  localparam pss_pkg::req_code_t REQ_SPARE5 = 3'd5;
  localparam pss_pkg::req_code_t REQ_SPARE6 = 3'd6;
  localparam pss_pkg::req_code_t REQ_SPARE7 = 3'd7;

  localparam pss_pkg::word_t ALL_ONES = {pss_pkg::WORD_W{1'b1}};

  typedef struct packed {
    pss_pkg::req_code_t req;
    pss_pkg::pos_t      first;
    pss_pkg::pos_t      second;
    pss_pkg::word_t     value;
    logic               typed;
    logic               ok;
    pss_pkg::len_out_t  len;
  } stim_row_t;

  typedef struct packed {
    logic              ok;
    pss_pkg::word_t    value;
    logic              last;
    pss_pkg::len_out_t len;
  } result_t;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  pss_pkg::req_code_t req_type;
  pss_pkg::pos_t      first_position;
  pss_pkg::pos_t      second_position;
  pss_pkg::word_t     item_value;
  logic               rsp_valid;
  logic               rsp_stall;
  logic               ok;
  pss_pkg::word_t     element_value;
  logic               last;
  pss_pkg::len_out_t  length_after;

  result_t        pending_results[$];
  pss_pkg::word_t shadow_words[DEPTH];
  int             shadow_len = 0;
  int             failures = 0;
  int             words_checked = 0;
  bit             calm = 1'b0;
  stim_row_t      directed_rows[25];

  positional_sequence_store #(.CAPACITY(DEPTH)) dut (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req_type        (req_type),
    .first_position  (first_position),
    .second_position (second_position),
    .item_value      (item_value),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .ok              (ok),
    .element_value   (element_value),
    .last            (last),
    .length_after    (length_after)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Shadow copy of the sequence: applies one request and, when asked, queues the
  // response words that it should produce.
  task automatic apply_to_shadow(input pss_pkg::req_code_t req, input pss_pkg::pos_t p1,
                                 input pss_pkg::pos_t p2, input pss_pkg::word_t v,
                                 input bit enqueue);
    int             pos;
    int             lo;
    int             hi;
    int             k;
    pss_pkg::word_t t;
    bit             done;
    int             dumped;
    result_t        r;
    done = 1'b0;
    dumped = 0;
    case (req)
      pss_pkg::REQ_INSERT: begin
        if (shadow_len < DEPTH && p1 >= 1) begin
          pos = (p1 > shadow_len + 1) ? shadow_len + 1 : int'(p1);
          for (k = shadow_len; k >= pos; k--) shadow_words[k] = shadow_words[k-1];
          shadow_words[pos-1] = v;
          shadow_len++;
          done = 1'b1;
        end
      end
      pss_pkg::REQ_REMOVE: begin
        if (shadow_len != 0 && p1 >= 1 && p1 <= shadow_len) begin
          for (k = p1 - 1; k + 1 < shadow_len; k++) shadow_words[k] = shadow_words[k+1];
          shadow_len--;
          done = 1'b1;
        end
      end
      pss_pkg::REQ_REVERSE: begin
        if (p1 >= 1 && p1 <= shadow_len && p2 >= 1 && p2 <= shadow_len && p1 <= p2) begin
          lo = p1 - 1;
          hi = p2 - 1;
          while (lo < hi) begin
            t = shadow_words[lo];
            shadow_words[lo] = shadow_words[hi];
            shadow_words[hi] = t;
            lo++;
            hi--;
          end
          done = 1'b1;
        end
      end
      pss_pkg::REQ_DUMP: begin
        for (k = 0; k < shadow_len; k++) begin
          r = '{1'b1, shadow_words[k], (k == shadow_len - 1),
                pss_pkg::len_out_t'(shadow_len)};
          if (enqueue) pending_results.push_back(r);
          dumped++;
        end
      end
      pss_pkg::REQ_CLEAR: begin
        shadow_len = 0;
        done = 1'b1;
      end
      default: done = 1'b0;
    endcase
    // Everything but a dump of a non-empty store answers with a single word.
    if (enqueue && dumped == 0)
      pending_results.push_back('{done, 64'd0, 1'b1, pss_pkg::len_out_t'(shadow_len)});
  endtask

  // Offers one request word, idling first at random, and records what it should
  // cause once the block takes it.
  task automatic send_request(input pss_pkg::req_code_t req, input pss_pkg::pos_t p1,
                              input pss_pkg::pos_t p2, input pss_pkg::word_t v,
                              input bit typed, input bit exp_ok,
                              input pss_pkg::len_out_t exp_len);
    while (!calm && $urandom_range(0, 99) < 37) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req_type = req;
    first_position = p1;
    second_position = p2;
    item_value = v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    apply_to_shadow(req, p1, p2, v, !typed);
    if (typed) pending_results.push_back('{exp_ok, 64'd0, 1'b1, exp_len});
    @(negedge clk);
  endtask

  function automatic pss_pkg::pos_t pick_position(input int top);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return pss_pkg::pos_t'(0);
    if (r < 14) return pss_pkg::pos_t'(255);
    if (r < 22) return pss_pkg::pos_t'($urandom_range(0, 255));
    return pss_pkg::pos_t'($urandom_range(1, (top < 1) ? 1 : top));
  endfunction

  function automatic pss_pkg::word_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return ALL_ONES;
    if (r < 20) return '0;
    return {$urandom, $urandom};
  endfunction

  // Response side: random stalls, plus one long hold-off once traffic is under way
  // so that the block backs up and stalls its request side.
  initial begin : response_side
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && words_checked >= 60) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        rsp_stall = 1'b1;
        hold_left--;
      end else begin
        rsp_stall = !calm && ($urandom_range(0, 99) < 37);
      end
    end
  end

  // Every accepted response word is matched against the oldest expectation.
  always @(posedge clk) begin : response_check
    result_t head;
    if (!rst && rsp_valid && !rsp_stall) begin
      words_checked++;
      if (pending_results.size() == 0) begin
        $error("response word with nothing expected: ok %0d value %h last %0d len %0d",
               ok, element_value, last, length_after);
        failures++;
      end else begin
        head = pending_results.pop_front();
        if (ok !== head.ok) begin
          $error("ok: expected %0d, got %0d", head.ok, ok);
          failures++;
        end
        if (element_value !== head.value) begin
          $error("element_value: expected %h, got %h", head.value, element_value);
          failures++;
        end
        if (last !== head.last) begin
          $error("last: expected %0d, got %0d", head.last, last);
          failures++;
        end
        if (length_after !== head.len) begin
          $error("length_after: expected %0d, got %0d", head.len, length_after);
          failures++;
        end
      end
    end
  end

  initial begin
    #(12 * 400000);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int                 n;
    int                 r;
    int                 mode;
    int                 w_ins;
    int                 w_rem;
    pss_pkg::req_code_t req;
    pss_pkg::pos_t      a;
    pss_pkg::pos_t      b;
    pss_pkg::pos_t      t;
    pss_pkg::word_t     v;

    rst = 1'b1;
    req_valid = 1'b0;
    req_type = pss_pkg::REQ_INSERT;
    first_position = '0;
    second_position = '0;
    item_value = '0;

    // Directed rows; those marked typed carry their one response word in full.
    directed_rows[0]  = '{pss_pkg::REQ_DUMP,    8'd0,   8'd0,   64'd0, 1'b1, 1'b0, 6'd0};
    directed_rows[1]  = '{pss_pkg::REQ_REMOVE,  8'd1,   8'd0,   64'd0, 1'b1, 1'b0, 6'd0};
    directed_rows[2]  = '{pss_pkg::REQ_REVERSE, 8'd1,   8'd1,   64'd0, 1'b1, 1'b0, 6'd0};
    directed_rows[3]  = '{pss_pkg::REQ_INSERT,  8'd0,   8'd0,   ALL_ONES, 1'b1, 1'b0, 6'd0};
    directed_rows[4]  = '{pss_pkg::REQ_INSERT,  8'd1,   8'd255, ALL_ONES, 1'b1, 1'b1, 6'd1};
    directed_rows[5]  = '{pss_pkg::REQ_INSERT,  8'd255, 8'd0,   64'd0, 1'b1, 1'b1, 6'd2};
    directed_rows[6]  = '{pss_pkg::REQ_INSERT,  8'd2,   8'd0,   64'h5555_5555_5555_5555,
                          1'b0, 1'b0, 6'd0};
    directed_rows[7]  = '{pss_pkg::REQ_INSERT,  8'd1,   8'd0,   64'hAAAA_AAAA_AAAA_AAAA,
                          1'b0, 1'b0, 6'd0};
    directed_rows[8]  = '{pss_pkg::REQ_INSERT,  8'd200, 8'd0,   64'h0123_4567_89AB_CDEF,
                          1'b0, 1'b0, 6'd0};
    directed_rows[9]  = '{pss_pkg::REQ_DUMP,    8'd0,   8'd0,   64'd0, 1'b0, 1'b0, 6'd0};
    directed_rows[10] = '{pss_pkg::REQ_REVERSE, 8'd1,   8'd5,   64'd0, 1'b0, 1'b0, 6'd0};
    directed_rows[11] = '{pss_pkg::REQ_REVERSE, 8'd4,   8'd2,   64'd0, 1'b1, 1'b0, 6'd5};
    directed_rows[12] = '{pss_pkg::REQ_REVERSE, 8'd0,   8'd3,   64'd0, 1'b1, 1'b0, 6'd5};
    directed_rows[13] = '{pss_pkg::REQ_REVERSE, 8'd2,   8'd255, 64'd0, 1'b1, 1'b0, 6'd5};
    directed_rows[14] = '{pss_pkg::REQ_REVERSE, 8'd3,   8'd3,   64'd0, 1'b0, 1'b0, 6'd0};
    directed_rows[15] = '{pss_pkg::REQ_REMOVE,  8'd0,   8'd0,   64'd0, 1'b1, 1'b0, 6'd5};
    directed_rows[16] = '{pss_pkg::REQ_REMOVE,  8'd6,   8'd0,   64'd0, 1'b1, 1'b0, 6'd5};
    directed_rows[17] = '{pss_pkg::REQ_REMOVE,  8'd5,   8'd0,   64'd0, 1'b0, 1'b0, 6'd0};
    directed_rows[18] = '{pss_pkg::REQ_REMOVE,  8'd1,   8'd0,   64'd0, 1'b0, 1'b0, 6'd0};
    directed_rows[19] = '{pss_pkg::REQ_DUMP,    8'd0,   8'd0,   64'd0, 1'b0, 1'b0, 6'd0};
    directed_rows[20] = '{REQ_SPARE5,           8'd1,   8'd1,   64'd0, 1'b1, 1'b0, 6'd3};
    directed_rows[21] = '{REQ_SPARE6,           8'd2,   8'd3,   64'd0, 1'b1, 1'b0, 6'd3};
    directed_rows[22] = '{REQ_SPARE7,           8'd255, 8'd255, ALL_ONES, 1'b1, 1'b0, 6'd3};
    directed_rows[23] = '{pss_pkg::REQ_CLEAR,   8'd0,   8'd0,   64'd0, 1'b1, 1'b1, 6'd0};
    directed_rows[24] = '{pss_pkg::REQ_DUMP,    8'd0,   8'd0,   64'd0, 1'b1, 1'b0, 6'd0};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].first, directed_rows[i].second,
                   directed_rows[i].value, directed_rows[i].typed, directed_rows[i].ok,
                   directed_rows[i].len);

    // Random traffic in phases that grow, churn and shrink the sequence, so that
    // it runs up to full and back down to empty more than once.
    for (n = 0; n < 300; n++) begin
      if (n == 100 || n == 250) begin
        req_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      calm = (n >= 150 && n < 200);
      mode = (n / 60) % 3;
      case (mode)
        0: begin
          w_ins = 70;
          w_rem = 5;
        end
        1: begin
          w_ins = 35;
          w_rem = 30;
        end
        default: begin
          w_ins = 20;
          w_rem = 55;
        end
      endcase
      r = $urandom_range(0, 99);
      a = pick_position(shadow_len);
      b = pick_position(shadow_len);
      v = pick_value();
      if (r < w_ins) begin
        req = pss_pkg::REQ_INSERT;
        a = pick_position(shadow_len + 1);
      end else if (r < w_ins + w_rem) begin
        req = pss_pkg::REQ_REMOVE;
      end else if (r < w_ins + w_rem + 13) begin
        req = pss_pkg::REQ_REVERSE;
        // Mostly well-ordered bounds; the rest stay inverted.
        if (a > b && $urandom_range(0, 99) < 80) begin
          t = a;
          a = b;
          b = t;
        end
      end else if (r < w_ins + w_rem + 21) begin
        req = pss_pkg::REQ_DUMP;
      end else if (r < w_ins + w_rem + 23) begin
        req = pss_pkg::REQ_CLEAR;
      end else begin
        req = pss_pkg::req_code_t'(REQ_SPARE5 + $urandom_range(0, 2));
      end
      send_request(req, a, b, v, 1'b0, 1'b0, '0);
    end
    calm = 1'b0;
    req_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- positional_sequence_store.f -----
+incdir+rtl/core
rtl/core/pss_pkg.sv
rtl/core/pss_mem.sv
rtl/core/pss_seq.sv
rtl/core/positional_sequence_store.sv
dv/positional_sequence_store_test.sv
